FILE: hdl/rpa_pkg.sv
// shared types, constants and helpers for the point rotation pipeline
`default_nettype none

package rpa_pkg;

  localparam int COR_W     = 36;
  localparam int SQ_CELLS  = 32;
  localparam int DIV_CELLS = 31;

  localparam logic signed [COR_W-1:0] GAIN_Q30    = 36'sd652032874;
  localparam logic signed [33:0]      PI_Q28      = 34'sd843314857;
  localparam logic signed [33:0]      TWO_PI_Q28  = 34'sd1686629713;
  localparam logic signed [33:0]      HALF_PI_Q28 = 34'sd421657428;

  typedef struct packed {
    logic [63:0] n;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [2:0][30:0] rem;
    logic [2:0][30:0] nlo;
    logic [2:0][30:0] quo;
    logic [30:0]      dvs;
  } div_t;

  typedef struct packed {
    logic signed [COR_W-1:0] x;
    logic signed [COR_W-1:0] y;
    logic signed [COR_W-1:0] z;
    logic                    neg;
  } cor_t;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0]       neg;
    logic [2:0][29:0] mag;
    logic             zero;
  } side_t;

  // arctangent of 2^-i in q6.30
  function automatic logic signed [COR_W-1:0] atan_q30(input int i);
    logic signed [COR_W-1:0] r;
    case (i)
      0: r = 36'sd843314857;
      1: r = 36'sd497837829;
      2: r = 36'sd263043837;
      3: r = 36'sd133525159;
      4: r = 36'sd67021687;
      5: r = 36'sd33543516;
      6: r = 36'sd16775851;
      7: r = 36'sd8388437;
      8: r = 36'sd4194283;
      9: r = 36'sd2097149;
      default: r = (i <= 30) ? (36'sd1 <<< (30 - i)) : '0;
    endcase
    return r;
  endfunction

  // round half up, drop 30 fraction bits
  function automatic logic signed [79:0] rnd30(input logic signed [79:0] x);
    return (x + 80'sd536870912) >>> 30;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rpa_sqrt_cell.sv
// one cell of the square root chain, one root bit per cell
`default_nettype none

module rpa_sqrt_cell
  import rpa_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire sq_t  d,
  output sq_t       q
);

  sq_t         res;
  logic [35:0] rem2;
  logic [35:0] trial;

  always_comb begin
    rem2  = {d.rem, d.n[63:62]};
    trial = {2'b00, d.root, 2'b01};
    res.n = {d.n[61:0], 2'b00};
    if (rem2 >= trial) begin
      res.rem  = 34'(rem2 - trial);
      res.root = {d.root[30:0], 1'b1};
    end else begin
      res.rem  = rem2[33:0];
      res.root = {d.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= res;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rpa_div_cell.sv
// one cell of the three-lane divider chain, one quotient bit per lane
`default_nettype none

module rpa_div_cell
  import rpa_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire div_t d,
  output div_t      q
);

  div_t        res;
  logic [31:0] rem2;

  always_comb begin
    res.dvs = d.dvs;
    rem2    = '0;
    for (int i = 0; i < 3; i++) begin
      rem2       = {d.rem[i], d.nlo[i][30]};
      res.nlo[i] = {d.nlo[i][29:0], 1'b0};
      if (rem2 >= {1'b0, d.dvs}) begin
        res.rem[i] = 31'(rem2 - {1'b0, d.dvs});
        res.quo[i] = {d.quo[i][29:0], 1'b1};
      end else begin
        res.rem[i] = rem2[30:0];
        res.quo[i] = {d.quo[i][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= res;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rpa_cordic_cell.sv
// one rotation cell of the sine and cosine chain
`default_nettype none

module rpa_cordic_cell
  import rpa_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire cor_t d,
  output cor_t      q
);

  localparam logic signed [COR_W-1:0] ANGLE = atan_q30(STAGE);

  cor_t                    res;
  logic signed [COR_W-1:0] xs;
  logic signed [COR_W-1:0] ys;

  always_comb begin
    xs      = d.x >>> STAGE;
    ys      = d.y >>> STAGE;
    res.neg = d.neg;
    if (!d.z[COR_W-1]) begin
      res.x = d.x - ys;
      res.y = d.y + xs;
      res.z = d.z - ANGLE;
    end else begin
      res.x = d.x + ys;
      res.y = d.y - xs;
      res.z = d.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= res;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rotate_point_about_axis.sv
// top level: rotation of a point about an axis through the origin
//
//  channel  | signals                  | contents
//  ---------+--------------------------+----------------------------------
//  in       | s_tvalid s_tready s_tdata| point xyz, axis xyz, angle
//  out      | m_tvalid m_tready m_tdata| rotated xyz
//           | m_tuser                  | zero axis, saturated
//
// one beat per cycle in and out while the output is not stalled; the data path runs
// through the root chain (32 cells), then the divider chain (31 cells) and the product stages
// the sine and cosine chain runs beside the root chain
// rst clears the valid bits of all stages
// a stalled output holds every stage; input is taken whenever the pipe moves
`default_nettype none

module rotate_point_about_axis
  import rpa_pkg::*;
#(
  parameter int COORD_WIDTH   = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // point_x, point_y, point_z, axis_x, axis_y, axis_z, turn_angle
  input  wire logic [223:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // rotated_x, rotated_y, rotated_z
  output logic [95:0]       m_tdata,
  // zero_axis, saturated
  output logic [1:0]        m_tuser
);

  localparam int LAT     = 78;
  localparam int DL_LEN  = 69 - CORDIC_STAGES;
  localparam int SAT_W   = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam logic signed [41:0] SAT_HI = (42'sd1 <<< (SAT_W - 1)) - 42'sd1;
  localparam logic signed [41:0] SAT_LO = -(42'sd1 <<< (SAT_W - 1));

  logic             adv;
  logic [LAT-1:0]   vld;

  // stage 0
  logic signed [31:0] in_p [3];
  logic signed [31:0] in_a [3];
  logic signed [31:0] in_ang;

  // stage 1
  logic signed [31:0] s1_p [3];
  logic [31:0]        s1_mag [3];
  logic [2:0]         s1_neg;
  logic               s1_zero;
  logic signed [33:0] s1_ang;
  logic               s1_cneg;

  logic [31:0]        mag_c [3];
  logic [2:0]         neg_c;
  logic signed [32:0] ax_c;
  logic signed [33:0] ang0_c;
  logic signed [33:0] ang1_c;
  logic signed [33:0] ang2_c;
  logic               cneg_c;

  // stage 2
  logic signed [31:0] s2_p [3];
  logic [31:0]        s2_mag [3];
  logic [2:0]         s2_neg;
  logic               s2_zero;
  logic [1:0]         s2_dn;
  logic [4:0]         s2_up;

  logic [31:0]        mx_c;
  logic [4:0]         lead_c;
  logic [1:0]         dn_c;
  logic [4:0]         up_c;

  // stages 3 to 69
  side_t              side_q [3:69];
  logic [59:0]        s4_sqr [3];
  sq_t                sq_head;
  sq_t                sq_q [1:SQ_CELLS];
  div_t               dv_head;
  div_t               dv_q [1:DIV_CELLS];
  logic [60:0]        num_c [3];

  cor_t               cor_start;
  cor_t               cor_q [1:CORDIC_STAGES];
  logic signed [COR_W-1:0] dl_cs [DL_LEN];
  logic signed [COR_W-1:0] dl_sn [DL_LEN];

  // stages 70 to 77
  logic signed [31:0] k70 [3];
  logic signed [31:0] p70 [3];
  logic               z70;

  logic signed [63:0] kp71 [3][3];
  logic signed [31:0] k71 [3];
  logic signed [31:0] p71 [3];
  logic signed [COR_W-1:0] cs71;
  logic signed [COR_W-1:0] sn71;
  logic               z71;

  logic signed [35:0] d72;
  logic signed [35:0] crr72 [3];
  logic signed [31:0] k72 [3];
  logic signed [31:0] p72 [3];
  logic signed [COR_W-1:0] cs72;
  logic signed [COR_W-1:0] sn72;
  logic               z72;

  logic signed [67:0] kd73 [3];
  logic signed [71:0] crsn73 [3];
  logic signed [31:0] p73 [3];
  logic signed [COR_W-1:0] cs73;
  logic               z73;

  logic signed [39:0] proj74 [3];
  logic signed [39:0] perp74 [3];
  logic signed [39:0] rsn74 [3];
  logic signed [COR_W-1:0] cs74;
  logic               z74;

  logic signed [75:0] pc75 [3];
  logic signed [39:0] proj75 [3];
  logic signed [39:0] rsn75 [3];
  logic               z75;

  logic signed [41:0] v76 [3];
  logic               z76;

  logic [31:0]        rx [3];
  logic               zero_q;
  logic               sat_q;
  logic [31:0]        rx_c [3];
  logic               sat_c;

  assign adv      = !vld[LAT-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];
  assign m_tdata  = {rx[2], rx[1], rx[0]};
  assign m_tuser  = {sat_q, zero_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // magnitudes and angle folding
  always_comb begin
    ax_c = '0;
    for (int i = 0; i < 3; i++) begin
      ax_c     = 33'(in_a[i]);
      neg_c[i] = ax_c[32];
      mag_c[i] = ax_c[32] ? 32'(-ax_c) : ax_c[31:0];
    end
    ang0_c = 34'(in_ang);
    if (ang0_c > PI_Q28) begin
      ang1_c = ang0_c - TWO_PI_Q28;
    end else if (ang0_c < -PI_Q28) begin
      ang1_c = ang0_c + TWO_PI_Q28;
    end else begin
      ang1_c = ang0_c;
    end
    cneg_c = 1'b1;
    if (ang1_c > HALF_PI_Q28) begin
      ang2_c = ang1_c - PI_Q28;
    end else if (ang1_c < -HALF_PI_Q28) begin
      ang2_c = ang1_c + PI_Q28;
    end else begin
      ang2_c = ang1_c;
      cneg_c = 1'b0;
    end
  end

  // normalising shift
  always_comb begin
    mx_c = s1_mag[0];
    if (s1_mag[1] > mx_c) mx_c = s1_mag[1];
    if (s1_mag[2] > mx_c) mx_c = s1_mag[2];
    lead_c = '0;
    for (int b = 0; b < 32; b++) begin
      if (mx_c[b]) lead_c = 5'(b);
    end
    if (lead_c >= 5'd30) begin
      dn_c = 2'(lead_c - 5'd29);
      up_c = '0;
    end else begin
      dn_c = '0;
      up_c = 5'd29 - lead_c;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_c[i] = (61'(side_q[37].mag[i]) << 30) + 61'(sq_q[SQ_CELLS].root[30:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        in_p[i] <= s_tdata[32*i +: 32];
        in_a[i] <= s_tdata[32*(i+3) +: 32];
      end
      in_ang <= s_tdata[223:192];

      for (int i = 0; i < 3; i++) begin
        s1_p[i]   <= in_p[i];
        s1_mag[i] <= mag_c[i];
      end
      s1_neg  <= neg_c;
      s1_zero <= (mag_c[0] == '0) && (mag_c[1] == '0) && (mag_c[2] == '0);
      s1_ang  <= ang2_c;
      s1_cneg <= cneg_c;

      for (int i = 0; i < 3; i++) begin
        s2_p[i]   <= s1_p[i];
        s2_mag[i] <= s1_mag[i];
      end
      s2_neg  <= s1_neg;
      s2_zero <= s1_zero;
      s2_dn   <= dn_c;
      s2_up   <= up_c;

      for (int i = 0; i < 3; i++) begin
        side_q[3].p[i]   <= s2_p[i];
        side_q[3].mag[i] <= 30'((s2_mag[i] >> s2_dn) << s2_up);
      end
      side_q[3].neg  <= s2_neg;
      side_q[3].zero <= s2_zero;
      for (int s = 4; s <= 69; s++) begin
        side_q[s] <= side_q[s-1];
      end

      for (int i = 0; i < 3; i++) begin
        s4_sqr[i] <= 60'(side_q[3].mag[i]) * 60'(side_q[3].mag[i]);
      end
      sq_head.n    <= 64'(s4_sqr[0]) + 64'(s4_sqr[1]) + 64'(s4_sqr[2]);
      sq_head.rem  <= '0;
      sq_head.root <= '0;

      for (int i = 0; i < 3; i++) begin
        dv_head.rem[i] <= {1'b0, num_c[i][60:31]};
        dv_head.nlo[i] <= num_c[i][30:0];
        dv_head.quo[i] <= '0;
      end
      dv_head.dvs <= sq_q[SQ_CELLS].root[30:0];

      dl_cs[0] <= cor_q[CORDIC_STAGES].neg ? -cor_q[CORDIC_STAGES].x
                                           : cor_q[CORDIC_STAGES].x;
      dl_sn[0] <= cor_q[CORDIC_STAGES].neg ? -cor_q[CORDIC_STAGES].y
                                           : cor_q[CORDIC_STAGES].y;
      for (int j = 1; j < DL_LEN; j++) begin
        dl_cs[j] <= dl_cs[j-1];
        dl_sn[j] <= dl_sn[j-1];
      end

      for (int i = 0; i < 3; i++) begin
        k70[i] <= side_q[69].neg[i] ? -$signed({1'b0, dv_q[DIV_CELLS].quo[i]})
                                    : $signed({1'b0, dv_q[DIV_CELLS].quo[i]});
        p70[i] <= side_q[69].p[i];
      end
      z70 <= side_q[69].zero;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          kp71[i][j] <= 64'(k70[i]) * 64'(p70[j]);
        end
        k71[i] <= k70[i];
        p71[i] <= p70[i];
      end
      cs71 <= dl_cs[DL_LEN-1];
      sn71 <= dl_sn[DL_LEN-1];
      z71  <= z70;

      d72 <= 36'(rnd30(80'(kp71[0][0]) + 80'(kp71[1][1]) + 80'(kp71[2][2])));
      crr72[0] <= 36'(rnd30(80'(kp71[1][2]) - 80'(kp71[2][1])));
      crr72[1] <= 36'(rnd30(80'(kp71[2][0]) - 80'(kp71[0][2])));
      crr72[2] <= 36'(rnd30(80'(kp71[0][1]) - 80'(kp71[1][0])));
      for (int i = 0; i < 3; i++) begin
        k72[i] <= k71[i];
        p72[i] <= p71[i];
      end
      cs72 <= cs71;
      sn72 <= sn71;
      z72  <= z71;

      for (int i = 0; i < 3; i++) begin
        kd73[i]   <= 68'(k72[i]) * 68'(d72);
        crsn73[i] <= 72'(crr72[i]) * 72'(sn72);
        p73[i]    <= p72[i];
      end
      cs73 <= cs72;
      z73  <= z72;

      for (int i = 0; i < 3; i++) begin
        proj74[i] <= 40'(rnd30(80'(kd73[i])));
        perp74[i] <= 40'(p73[i]) - 40'(rnd30(80'(kd73[i])));
        rsn74[i]  <= 40'(rnd30(80'(crsn73[i])));
      end
      cs74 <= cs73;
      z74  <= z73;

      for (int i = 0; i < 3; i++) begin
        pc75[i]   <= 76'(perp74[i]) * 76'(cs74);
        proj75[i] <= proj74[i];
        rsn75[i]  <= rsn74[i];
      end
      z75 <= z74;

      for (int i = 0; i < 3; i++) begin
        v76[i] <= 42'(proj75[i]) + 42'(rnd30(80'(pc75[i]))) + 42'(rsn75[i]);
      end
      z76 <= z75;

      for (int i = 0; i < 3; i++) begin
        rx[i] <= rx_c[i];
      end
      zero_q <= z76;
      sat_q  <= sat_c;
    end
  end

  // clamp to the output range, zero output for a zero axis
  always_comb begin
    sat_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (z76) begin
        rx_c[i] = '0;
      end else if (v76[i] > SAT_HI) begin
        rx_c[i] = SAT_HI[31:0];
        sat_c   = 1'b1;
      end else if (v76[i] < SAT_LO) begin
        rx_c[i] = SAT_LO[31:0];
        sat_c   = 1'b1;
      end else begin
        rx_c[i] = v76[i][31:0];
      end
    end
  end

  always_comb begin
    cor_start.x   = GAIN_Q30;
    cor_start.y   = '0;
    cor_start.z   = 36'(s1_ang) <<< 2;
    cor_start.neg = s1_cneg;
  end

  genvar g;

  generate
    for (g = 0; g < CORDIC_STAGES; g++) begin : g_cor
      if (g == 0) begin : g_first
        rpa_cordic_cell #(.STAGE(g)) u_cell (
          .clk (clk),
          .en  (adv),
          .d   (cor_start),
          .q   (cor_q[1])
        );
      end else begin : g_rest
        rpa_cordic_cell #(.STAGE(g)) u_cell (
          .clk (clk),
          .en  (adv),
          .d   (cor_q[g]),
          .q   (cor_q[g+1])
        );
      end
    end

    for (g = 0; g < SQ_CELLS; g++) begin : g_sq
      if (g == 0) begin : g_first
        rpa_sqrt_cell u_cell (
          .clk (clk),
          .en  (adv),
          .d   (sq_head),
          .q   (sq_q[1])
        );
      end else begin : g_rest
        rpa_sqrt_cell u_cell (
          .clk (clk),
          .en  (adv),
          .d   (sq_q[g]),
          .q   (sq_q[g+1])
        );
      end
    end

    for (g = 0; g < DIV_CELLS; g++) begin : g_div
      if (g == 0) begin : g_first
        rpa_div_cell u_cell (
          .clk (clk),
          .en  (adv),
          .d   (dv_head),
          .q   (dv_q[1])
        );
      end else begin : g_rest
        rpa_div_cell u_cell (
          .clk (clk),
          .en  (adv),
          .d   (dv_q[g]),
          .q   (dv_q[g+1])
        );
      end
    end
  endgenerate

endmodule

`default_nettype wire
